// ===== sv/ppts_pkg.sv =====
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types, codes and defaults for the preemptive priority task scheduler.
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_WIDTH  = 32;

  localparam int ID_W    = 8;
  localparam int DUR_W   = 16;
  localparam int FTIME_W = 32;

  // operation codes of an input transaction
  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_DONE   = 2'd2;

  // configuration register indexes
  localparam logic CFG_PRIORITY_MODE  = 1'b0;
  localparam logic CFG_HARD_DEADLINES = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_ACCEPTED = 3'd1,
    CMD_OVERFLOW = 3'd2,
    CMD_DISPATCH = 3'd3,
    CMD_PREEMPT  = 3'd4,
    CMD_ABORT    = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ID_W-1:0]    task_id;
    logic [DUR_W-1:0]   task_duration;
    logic [FTIME_W-1:0] task_deadline;
    logic [FTIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      command;
    logic [ID_W-1:0] out_task_id;
    logic            last;
  } out_item_t;

  // queue command from the controller to the cell chain
  typedef struct packed {
    logic pop;
    logic load;
  } qcmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INS_WAIT,
    ST_ACK,
    ST_REQ,
    ST_DISP2,
    ST_HARD,
    ST_REDISP
  } fsm_t;

endpackage

// ===== sv/ppts_cell.sv =====
// ----------------------------------------------------------------------------
// ppts_cell
// One queue slot: holds a task, takes a carried task walking down the chain,
// and shifts toward the head on a pop.
// ----------------------------------------------------------------------------
module ppts_cell #(
  parameter int TW = ppts_pkg::TIME_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      mode,
  input  logic                      occ,
  input  logic                      pop,
  input  logic [ppts_pkg::ID_W-1:0] nb_id,
  input  logic [ppts_pkg::DUR_W-1:0] nb_dur,
  input  logic [TW-1:0]             nb_dl,
  input  logic                      cin_valid,
  input  logic                      cin_shift,
  input  logic [ppts_pkg::ID_W-1:0] cin_id,
  input  logic [ppts_pkg::DUR_W-1:0] cin_dur,
  input  logic [TW-1:0]             cin_dl,
  output logic [ppts_pkg::ID_W-1:0] ent_id,
  output logic [ppts_pkg::DUR_W-1:0] ent_dur,
  output logic [TW-1:0]             ent_dl,
  output logic                      cout_valid,
  output logic                      cout_shift,
  output logic [ppts_pkg::ID_W-1:0] cout_id,
  output logic [ppts_pkg::DUR_W-1:0] cout_dur,
  output logic [TW-1:0]             cout_dl,
  output logic                      dep
);
  import ppts_pkg::*;

  localparam int KW = (TW > DUR_W) ? TW : DUR_W;

  logic [ID_W-1:0]  id_r, id_nxt;
  logic [DUR_W-1:0] dur_r, dur_nxt;
  logic [TW-1:0]    dl_r, dl_nxt;
  logic             cv_r, cv_nxt;
  logic             cs_r, cs_nxt;
  logic [ID_W-1:0]  cid_r, cid_nxt;
  logic [DUR_W-1:0] cdur_r, cdur_nxt;
  logic [TW-1:0]    cdl_r, cdl_nxt;
  logic [KW-1:0]    cin_key, my_key;

  assign cin_key = mode ? KW'(cin_dl) : KW'(cin_dur);
  assign my_key  = mode ? KW'(dl_r)   : KW'(dur_r);

  always_comb begin
    id_nxt   = id_r;
    dur_nxt  = dur_r;
    dl_nxt   = dl_r;
    cv_nxt   = 1'b0;
    cs_nxt   = cs_r;
    cid_nxt  = cid_r;
    cdur_nxt = cdur_r;
    cdl_nxt  = cdl_r;
    dep      = 1'b0;
    if (pop) begin
      id_nxt  = nb_id;
      dur_nxt = nb_dur;
      dl_nxt  = nb_dl;
    end else if (cin_valid) begin
      if (!occ) begin
        // first free slot: deposit here
        id_nxt  = cin_id;
        dur_nxt = cin_dur;
        dl_nxt  = cin_dl;
        dep     = 1'b1;
      end else if (cin_shift || (cin_key < my_key)) begin
        // take the carried task, push ours on down the chain
        id_nxt   = cin_id;
        dur_nxt  = cin_dur;
        dl_nxt   = cin_dl;
        cv_nxt   = 1'b1;
        cs_nxt   = 1'b1;
        cid_nxt  = id_r;
        cdur_nxt = dur_r;
        cdl_nxt  = dl_r;
      end else begin
        cv_nxt   = 1'b1;
        cs_nxt   = 1'b0;
        cid_nxt  = cin_id;
        cdur_nxt = cin_dur;
        cdl_nxt  = cin_dl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= cv_nxt;
    end
    id_r   <= id_nxt;
    dur_r  <= dur_nxt;
    dl_r   <= dl_nxt;
    cs_r   <= cs_nxt;
    cid_r  <= cid_nxt;
    cdur_r <= cdur_nxt;
    cdl_r  <= cdl_nxt;
  end

  assign ent_id     = id_r;
  assign ent_dur    = dur_r;
  assign ent_dl     = dl_r;
  assign cout_valid = cv_r;
  assign cout_shift = cs_r;
  assign cout_id    = cid_r;
  assign cout_dur   = cdur_r;
  assign cout_dl    = cdl_r;

endmodule

// ===== sv/ppts_chain.sv =====
// ----------------------------------------------------------------------------
// ppts_chain
// Sorted wait queue as a row of cells; the head sits in cell 0.
// ----------------------------------------------------------------------------
module ppts_chain #(
  parameter int DEPTH = ppts_pkg::QUEUE_DEPTH,
  parameter int TW    = ppts_pkg::TIME_WIDTH,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       mode,
  input  logic [CW-1:0]              cnt,
  input  ppts_pkg::qcmd_t            qcmd,
  input  logic [ppts_pkg::ID_W-1:0]  ld_id,
  input  logic [ppts_pkg::DUR_W-1:0] ld_dur,
  input  logic [TW-1:0]              ld_dl,
  output logic [ppts_pkg::ID_W-1:0]  head_id,
  output logic [ppts_pkg::DUR_W-1:0] head_dur,
  output logic [TW-1:0]              head_dl,
  output logic                       ins_done
);
  import ppts_pkg::*;

  logic [ID_W-1:0]  e_id  [DEPTH];
  logic [DUR_W-1:0] e_dur [DEPTH];
  logic [TW-1:0]    e_dl  [DEPTH];
  logic [ID_W-1:0]  n_id  [DEPTH];
  logic [DUR_W-1:0] n_dur [DEPTH];
  logic [TW-1:0]    n_dl  [DEPTH];
  logic             c_v   [DEPTH+1];
  logic             c_s   [DEPTH+1];
  logic [ID_W-1:0]  c_id  [DEPTH+1];
  logic [DUR_W-1:0] c_dur [DEPTH+1];
  logic [TW-1:0]    c_dl  [DEPTH+1];
  logic [DEPTH-1:0] dep;
  logic             ld_v_r;

  // launch the new task into the head cell in the cycle after the load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_v_r <= 1'b0;
    end else begin
      ld_v_r <= qcmd.load;
    end
  end

  assign c_v[0]   = ld_v_r;
  assign c_s[0]   = 1'b0;
  assign c_id[0]  = ld_id;
  assign c_dur[0] = ld_dur;
  assign c_dl[0]  = ld_dl;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_nb
      assign n_id[i]  = e_id[i+1];
      assign n_dur[i] = e_dur[i+1];
      assign n_dl[i]  = e_dl[i+1];
    end else begin : g_end
      assign n_id[i]  = e_id[i];
      assign n_dur[i] = e_dur[i];
      assign n_dl[i]  = e_dl[i];
    end

    ppts_cell #(.TW(TW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .mode      (mode),
      .occ       (cnt > CW'(i)),
      .pop       (qcmd.pop),
      .nb_id     (n_id[i]),
      .nb_dur    (n_dur[i]),
      .nb_dl     (n_dl[i]),
      .cin_valid (c_v[i]),
      .cin_shift (c_s[i]),
      .cin_id    (c_id[i]),
      .cin_dur   (c_dur[i]),
      .cin_dl    (c_dl[i]),
      .ent_id    (e_id[i]),
      .ent_dur   (e_dur[i]),
      .ent_dl    (e_dl[i]),
      .cout_valid(c_v[i+1]),
      .cout_shift(c_s[i+1]),
      .cout_id   (c_id[i+1]),
      .cout_dur  (c_dur[i+1]),
      .cout_dl   (c_dl[i+1]),
      .dep       (dep[i])
    );
  end

  assign head_id  = e_id[0];
  assign head_dur = e_dur[0];
  assign head_dl  = e_dl[0];
  assign ins_done = |dep;

endmodule

// ===== sv/preemptive_priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_task_scheduler
// Sorted wait queue plus one running task, with dispatch, preemption and,
// when hard deadlines are set, deadline abort on each scheduling tick.
// ----------------------------------------------------------------------------
// One input transaction is handled at a time. An accepted arrival waits
// while the new task walks down the cell chain, one cell per cycle, to its
// insertion slot; a preempted running task is requeued the same way during
// its tick. Each result waits for the output register to be free; the next
// item is taken while the last result of the previous one is still held
// there. Configuration writes are always ready and take effect at once.
module preemptive_priority_task_scheduler #(
  parameter int QUEUE_DEPTH = ppts_pkg::QUEUE_DEPTH,
  parameter int TIME_WIDTH  = ppts_pkg::TIME_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ppts_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic                cfg_data
);
  import ppts_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = (TW > DUR_W) ? TW : DUR_W;

  fsm_t             state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [ID_W-1:0]  tid_r, tid_nxt;
  logic [DUR_W-1:0] tdur_r, tdur_nxt;
  logic [TW-1:0]    tdl_r, tdl_nxt;
  logic [TW-1:0]    now_r, now_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_v_r, run_v_nxt;
  logic [ID_W-1:0]  run_id_r, run_id_nxt;
  logic [DUR_W-1:0] run_dur_r, run_dur_nxt;
  logic [TW-1:0]    run_dl_r, run_dl_nxt;
  logic             emitted_r, emitted_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             mode_r, hard_r;

  qcmd_t            qcmd;
  logic [ID_W-1:0]  head_id;
  logic [DUR_W-1:0] head_dur;
  logic [TW-1:0]    head_dl;
  logic             ins_done;
  logic [KW-1:0]    head_key, run_key;
  logic             slot_free, emit, q_empty, q_full;
  logic             head_late, run_late;
  out_item_t        emit_data;

  ppts_chain #(
    .DEPTH(QUEUE_DEPTH),
    .TW   (TW),
    .CW   (CW)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_r),
    .cnt     (cnt_r),
    .qcmd    (qcmd),
    .ld_id   (tid_r),
    .ld_dur  (tdur_r),
    .ld_dl   (tdl_r),
    .head_id (head_id),
    .head_dur(head_dur),
    .head_dl (head_dl),
    .ins_done(ins_done)
  );

  assign head_key  = mode_r ? KW'(head_dl)  : KW'(head_dur);
  assign run_key   = mode_r ? KW'(run_dl_r) : KW'(run_dur_r);
  assign head_late = head_dl <= now_r;
  assign run_late  = run_dl_r <= now_r;
  assign q_empty   = cnt_r == '0;
  assign q_full    = cnt_r == CW'(QUEUE_DEPTH);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    tid_nxt     = tid_r;
    tdur_nxt    = tdur_r;
    tdl_nxt     = tdl_r;
    now_nxt     = now_r;
    cnt_nxt     = cnt_r;
    run_v_nxt   = run_v_r;
    run_id_nxt  = run_id_r;
    run_dur_nxt = run_dur_r;
    run_dl_nxt  = run_dl_r;
    emitted_nxt = emitted_r;
    qcmd        = '0;
    in_ready    = 1'b0;
    emit        = 1'b0;
    emit_data   = '{command: CMD_NONE, out_task_id: '0, last: 1'b1};

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt      = in_data.operation;
          tid_nxt     = in_data.task_id;
          tdur_nxt    = in_data.task_duration;
          tdl_nxt     = TW'(in_data.task_deadline);
          now_nxt     = TW'(in_data.now);
          emitted_nxt = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (op_r)
          OP_ARRIVE: begin
            if (q_full) begin
              if (slot_free) begin
                emit      = 1'b1;
                emit_data = '{command: CMD_OVERFLOW, out_task_id: tid_r, last: 1'b1};
                state_nxt = ST_IDLE;
              end
            end else begin
              qcmd.load = 1'b1;
              state_nxt = ST_INS_WAIT;
            end
          end
          OP_TICK: begin
            if (!q_empty && !run_v_r) begin
              if (slot_free) begin
                qcmd.pop    = 1'b1;
                cnt_nxt     = cnt_r - 1'b1;
                run_v_nxt   = 1'b1;
                run_id_nxt  = head_id;
                run_dur_nxt = head_dur;
                run_dl_nxt  = head_dl;
                emit        = 1'b1;
                emit_data   = '{command: CMD_DISPATCH, out_task_id: head_id,
                                last: !(hard_r && head_late)};
                emitted_nxt = 1'b1;
                state_nxt   = ST_HARD;
              end
            end else if (!q_empty && (run_key > head_key)) begin
              if (slot_free) begin
                // park the preempted task, requeue it after the pop
                qcmd.pop    = 1'b1;
                cnt_nxt     = cnt_r - 1'b1;
                tid_nxt     = run_id_r;
                tdur_nxt    = run_dur_r;
                tdl_nxt     = run_dl_r;
                run_id_nxt  = head_id;
                run_dur_nxt = head_dur;
                run_dl_nxt  = head_dl;
                emit        = 1'b1;
                emit_data   = '{command: CMD_PREEMPT, out_task_id: run_id_r, last: 1'b0};
                emitted_nxt = 1'b1;
                state_nxt   = ST_REQ;
              end
            end else begin
              state_nxt = ST_HARD;
            end
          end
          OP_DONE: begin
            if (slot_free) begin
              run_v_nxt = 1'b0;
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            if (slot_free) begin
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end

      ST_INS_WAIT: begin
        if (ins_done) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = (op_r == OP_ARRIVE) ? ST_ACK : ST_DISP2;
        end
      end

      ST_ACK: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = '{command: CMD_ACCEPTED, out_task_id: tid_r, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end

      ST_REQ: begin
        qcmd.load = 1'b1;
        state_nxt = ST_INS_WAIT;
      end

      ST_DISP2: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = '{command: CMD_DISPATCH, out_task_id: run_id_r,
                        last: !(hard_r && run_late)};
          state_nxt = ST_HARD;
        end
      end

      ST_HARD: begin
        if (hard_r && run_v_r && run_late) begin
          if (slot_free) begin
            run_v_nxt   = 1'b0;
            emit        = 1'b1;
            emit_data   = '{command: CMD_ABORT, out_task_id: run_id_r, last: q_empty};
            emitted_nxt = 1'b1;
            state_nxt   = q_empty ? ST_IDLE : ST_REDISP;
          end
        end else if (!emitted_r) begin
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_REDISP: begin
        if (slot_free) begin
          qcmd.pop    = 1'b1;
          cnt_nxt     = cnt_r - 1'b1;
          run_v_nxt   = 1'b1;
          run_id_nxt  = head_id;
          run_dur_nxt = head_dur;
          run_dl_nxt  = head_dl;
          emit        = 1'b1;
          emit_data   = '{command: CMD_DISPATCH, out_task_id: head_id, last: 1'b1};
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      run_v_r     <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      hard_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      run_v_r   <= run_v_nxt;
      emitted_r <= emitted_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PRIORITY_MODE:  mode_r <= cfg_data;
          CFG_HARD_DEADLINES: hard_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    tid_r     <= tid_nxt;
    tdur_r    <= tdur_nxt;
    tdl_r     <= tdl_nxt;
    now_r     <= now_nxt;
    run_id_r  <= run_id_nxt;
    run_dur_r <= run_dur_nxt;
    run_dl_r  <= run_dl_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    qcmd.pop |-> !q_empty)
    else $error("pop from empty queue");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_WAIT) |-> !q_full)
    else $error("insertion into full queue");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ins_done |-> (state_r == ST_INS_WAIT))
    else $error("insertion finished outside wait state");

  a_load_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    qcmd.load |=> (state_r == ST_INS_WAIT))
    else $error("load not followed by insertion wait");

endmodule

// ===== tb/ppts_checker.sv =====
// ----------------------------------------------------------------------------
// ppts_checker
// Scoreboard for the preemptive priority task scheduler.
// ----------------------------------------------------------------------------
// Watches the input, result and configuration channels at the rising edge.
// Each accepted input transaction runs through a cycle-free model of the
// wait queue and the running task. The model queues the result transactions
// that the block must produce, and the checker compares every accepted
// result with the oldest of them. Mismatches and unexpected results are
// counted. The number of results still owed is passed to the top module.
// ----------------------------------------------------------------------------
module ppts_checker
  import ppts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic      cfg_data,
  output int        n_errors,
  output int        n_pending
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [DUR_W-1:0]      duration;
    logic [TIME_WIDTH-1:0] deadline;
  } sched_task_t;

  sched_task_t wait_list [QUEUE_DEPTH];
  int          wait_len;
  logic        busy;
  sched_task_t current;
  logic        edf_mode;
  logic        hard_mode;
  out_item_t   expected_q [$];
  out_item_t   exp_r;

  function automatic logic [63:0] task_key(sched_task_t t);
    return edf_mode ? 64'(t.deadline) : 64'(t.duration);
  endfunction

  // insert behind every entry whose key is not strictly greater
  task automatic enqueue_task(input sched_task_t t);
    int pos;
    pos = 0;
    while (pos < wait_len && !(task_key(t) < task_key(wait_list[pos]))) pos++;
    for (int i = wait_len; i > pos; i--) wait_list[i] = wait_list[i-1];
    wait_list[pos] = t;
    wait_len++;
  endtask

  task automatic dequeue_head(output sched_task_t h);
    h = wait_list[0];
    for (int i = 0; i < wait_len - 1; i++) wait_list[i] = wait_list[i+1];
    wait_len--;
  endtask

  task automatic post_result(input cmd_t c, input logic [ID_W-1:0] id);
    out_item_t r;
    r.command     = c;
    r.out_task_id = id;
    r.last        = 1'b0;
    expected_q.push_back(r);
  endtask

  task automatic predict_results(input in_item_t it);
    sched_task_t           t;
    sched_task_t           head;
    sched_task_t           prev;
    logic [TIME_WIDTH-1:0] tnow;
    out_item_t             r;
    int                    first;
    first = expected_q.size();
    tnow  = it.now[TIME_WIDTH-1:0];
    case (it.operation)
      OP_ARRIVE: begin
        t.id       = it.task_id;
        t.duration = it.task_duration;
        t.deadline = it.task_deadline[TIME_WIDTH-1:0];
        if (wait_len >= QUEUE_DEPTH) begin
          post_result(CMD_OVERFLOW, t.id);
        end else begin
          enqueue_task(t);
          post_result(CMD_ACCEPTED, t.id);
        end
      end
      OP_TICK: begin
        if (wait_len > 0) begin
          if (!busy) begin
            dequeue_head(current);
            busy = 1'b1;
            post_result(CMD_DISPATCH, current.id);
          end else if (task_key(current) > task_key(wait_list[0])) begin
            // pop first so the requeued task always fits
            dequeue_head(head);
            prev = current;
            enqueue_task(prev);
            current = head;
            post_result(CMD_PREEMPT, prev.id);
            post_result(CMD_DISPATCH, head.id);
          end
        end
        if (hard_mode && busy && current.deadline <= tnow) begin
          post_result(CMD_ABORT, current.id);
          busy = 1'b0;
          if (wait_len > 0) begin
            dequeue_head(current);
            busy = 1'b1;
            post_result(CMD_DISPATCH, current.id);
          end
        end
      end
      OP_DONE: busy = 1'b0;
      default: ;
    endcase
    if (expected_q.size() == first) post_result(CMD_NONE, '0);
    // flag the final result of this transaction
    r = expected_q.pop_back();
    r.last = 1'b1;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wait_len  = 0;
      busy      = 1'b0;
      current   = '0;
      edf_mode  = 1'b0;
      hard_mode = 1'b0;
      n_errors  = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("unexpected result: command %0d id %0d last %0d",
                     out_data.command, out_data.out_task_id, out_data.last);
          n_errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data.command !== exp_r.command ||
              out_data.out_task_id !== exp_r.out_task_id ||
              out_data.last !== exp_r.last) begin
            if (n_errors < MAX_REPORTS)
              $display("result mismatch: expected command %0d id %0d last %0d, got %0d %0d %0d",
                       exp_r.command, exp_r.out_task_id, exp_r.last,
                       out_data.command, out_data.out_task_id, out_data.last);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready) predict_results(in_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRIORITY_MODE) edf_mode = cfg_data;
        else hard_mode = cfg_data;
      end
    end
    n_pending = expected_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the preemptive priority task scheduler.
// ----------------------------------------------------------------------------
// Drives a short directed sequence (idle done, unused operation, empty tick,
// equal keys, preemption, deadline abort at the boundary, a tick with all
// four results), then random transactions under every register setting.
// Arrival-heavy segments fill the queue to overflow and tick-heavy segments
// drain it. Sender and receiver stall at random in two phases and run
// without stalls in a third. Checking is done by ppts_checker.
// ----------------------------------------------------------------------------
module tb;
  import ppts_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         NUM_SEGMENTS   = 6;
  localparam int         SEGMENT_ITEMS  = 21;
  localparam int         SETTLE_CYCLES  = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_index = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_ready;
  int        n_errors;
  int        n_pending;
  int        send_idle_pct = 30;
  int        recv_idle_pct = 67;
  logic [FTIME_W-1:0] sim_clock = '0;

  preemptive_priority_task_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppts_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  initial forever #5 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // present one input transaction and hold it until accepted
  task automatic push_item(input logic [1:0] op, input logic [ID_W-1:0] id,
                           input logic [DUR_W-1:0] dur, input logic [FTIME_W-1:0] dl,
                           input logic [FTIME_W-1:0] tnow);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, id, dur, dl, tnow};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // write both registers back to back, valid held across the pair
  task automatic set_config(input logic edf, input logic hard);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? CFG_PRIORITY_MODE : CFG_HARD_DEADLINES;
      cfg_data  <= (i == 0) ? edf : hard;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (n_pending != 0) @(negedge clk);
  endtask

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int                 r;
    int                 arrive_pct;
    logic [1:0]         op;
    logic [DUR_W-1:0]   dur;
    logic [FTIME_W-1:0] dl;
    logic [FTIME_W-1:0] tnow;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_config(1'b0, 1'b0);

    // shortest duration first, no aborts
    push_item(OP_DONE,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_UNUSED, 8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_ARRIVE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(OP_ARRIVE, 8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_ARRIVE, 8'h01, 16'h0000, 32'h0000_0005, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_DONE,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_DONE,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_ARRIVE, 8'h03, 16'h000A, 32'h0000_0064, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    in_valid <= 1'b0;
    drain();

    // earliest deadline first with aborts
    set_config(1'b1, 1'b1);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0063);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0064);
    push_item(OP_ARRIVE, 8'h04, 16'h0001, 32'h0000_0032, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(OP_ARRIVE, 8'h05, 16'h0007, 32'h0000_000A, 32'h0000_0000);
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_ARRIVE, 8'h06, 16'h0009, 32'h0000_0005, 32'h0000_0000);
    // preempt, dispatch, abort and redispatch in one tick
    push_item(OP_TICK,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0014);
    push_item(OP_DONE,   8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    in_valid <= 1'b0;
    drain();

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 67;
      end else if (seg < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // fill the wait queue in most segments and drain it in segments 3 and 5
      arrive_pct = (seg == 3 || seg == 5) ? 25 : 65;
      set_config(1'(seg % 2), 1'(((seg + 1) / 2) % 2));
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < arrive_pct) begin
          op = OP_ARRIVE;
        end else begin
          r  = $urandom_range(0, 9);
          op = (r < 6) ? OP_TICK : (r < 9) ? OP_DONE : OP_UNUSED;
        end
        dur = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0:       dl = '0;
          1:       dl = '1;
          2, 3:    dl = $urandom;
          default: dl = sim_clock + $urandom_range(0, 40);
        endcase
        if (op == OP_TICK) sim_clock = sim_clock + $urandom_range(0, 6);
        case ($urandom_range(0, 19))
          0:       tnow = '1;
          1:       tnow = '0;
          2, 3:    tnow = $urandom;
          default: tnow = sim_clock;
        endcase
        push_item(op, 8'($urandom), dur, dl, tnow);
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
